// ===== rtl/core/lcw_pkg.sv =====
// Shared types and constants for the LCW decompressor core.
package lcw_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 65536;

    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_DATA  = 2'd1;
    localparam logic [1:0] RK_END   = 2'd2;
    localparam logic [1:0] RK_ERROR = 2'd3;

    localparam logic [2:0] PH_CMD     = 3'd0;
    localparam logic [2:0] PH_LIT     = 3'd1;
    localparam logic [2:0] PH_OP0     = 3'd2;
    localparam logic [2:0] PH_OP1     = 3'd3;
    localparam logic [2:0] PH_OP2     = 3'd4;
    localparam logic [2:0] PH_OP3     = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_DELIVER = 3'd7;

    localparam logic [2:0] K_LIT    = 3'd0;
    localparam logic [2:0] K_SHORT  = 3'd1;
    localparam logic [2:0] K_MEDIUM = 3'd2;
    localparam logic [2:0] K_FILL   = 3'd3;
    localparam logic [2:0] K_LONG   = 3'd4;

    localparam logic [7:0] B_END  = 8'h80;
    localparam logic [7:0] B_FILL = 8'hfe;
    localparam logic [7:0] B_LONG = 8'hff;

endpackage

// ===== rtl/core/lcw_hist_ram.sv =====
// History ring memory: one write port, one registered read port.
module lcw_hist_ram #(
    parameter int unsigned AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [(2**AW)-1:0];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/lcw_decompressor_core.sv =====
// Top level of the LCW decompressor: parser, copy engine and output register.
//
// Pushes, fill bytes and error answers are taken at one transaction per cycle while no
// copy read is in flight, with the result registered at the accepting edge. A request
// for a copy byte holds the input while the busy register is set: the accepting cycle
// reads the history memory, and the cycle after writes the read byte back to the history
// and loads the output register. The pace is set by the registered read of the history
// memory, whose next read can depend on the byte just written. The history needs no
// clearing pass, since a back reference only reaches bytes already written in the current
// stream. A single result register drives the output; the input stalls while a result
// waits unaccepted. HISTORY_DEPTH must be a power of two.
module lcw_decompressor_core #(
    parameter int unsigned HISTORY_DEPTH = lcw_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_in,
    input  logic        i_stream_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_data_out,
    output logic        o_output_pending,
    output logic        o_limit_reached
);
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam logic [32:0] DEPTH33 = 33'(HISTORY_DEPTH);

    logic [23:0]   r_size;
    logic [31:0]   r_ocnt;
    logic [AW-1:0] r_widx;
    logic          r_rel;
    logic [2:0]    r_phase;
    logic [2:0]    r_kind;
    logic [15:0]   r_run;
    logic [15:0]   r_src;
    logic [AW-1:0] r_csrc;
    logic [7:0]    r_fill;
    logic [23:0]   r_cons;

    // copy request in progress: the history read data is being used
    logic          r_busy;
    logic          r_out_v;
    logic [1:0]    r_out_k;
    logic [7:0]    r_out_d;
    logic          r_out_p;
    logic          r_out_l;

    logic [7:0] w_rdata;
    logic       w_acc;
    logic       w_copy_rd;
    logic       w_we;
    logic [7:0] w_wdata;

    assign o_ready   = !r_busy && (!r_out_v || i_ready);
    assign w_acc     = i_valid && o_ready;
    assign w_copy_rd = w_acc && i_opcode && (r_phase == lcw_pkg::PH_DELIVER)
                       && (r_kind != lcw_pkg::K_FILL);

    lcw_hist_ram #(.AW(AW)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_widx),
        .i_wdata (w_wdata),
        .i_re    (w_copy_rd),
        .i_raddr (r_csrc),
        .o_rdata (w_rdata)
    );

    logic [31:0]   n_ocnt;
    logic [AW-1:0] n_widx;
    logic          n_rel;
    logic [2:0]    n_phase;
    logic [2:0]    n_kind;
    logic [15:0]   n_run;
    logic [15:0]   n_src;
    logic [AW-1:0] n_csrc;
    logic [7:0]    n_fill;
    logic [23:0]   n_cons;
    logic          n_busy;
    logic          n_out_v;
    logic [1:0]    n_out_k;
    logic [7:0]    n_out_d;
    logic          n_out_l;
    logic          n_emit;
    logic [7:0]    n_eb;

    always_comb begin
        logic [15:0] pos;
        logic        rel;
        logic        start;
        logic        bad;
        logic [32:0] span;
        logic [23:0] cons1;
        n_ocnt = r_ocnt; n_widx = r_widx; n_rel = r_rel; n_phase = r_phase;
        n_kind = r_kind; n_run = r_run; n_src = r_src; n_csrc = r_csrc;
        n_fill = r_fill; n_cons = r_cons; n_busy = 1'b0;
        n_out_v = r_out_v && !i_ready; n_out_k = r_out_k; n_out_d = r_out_d;
        n_out_l = r_out_l; n_emit = 1'b0; n_eb = r_fill;
        pos = 16'd0; rel = 1'b0; start = 1'b0; bad = 1'b0; span = 33'd0;
        cons1 = (r_cons == 24'hffffff) ? r_cons : r_cons + 24'd1;

        if (r_busy) begin
            // finish copy byte with the read data
            n_emit = 1'b1; n_eb = w_rdata;
            n_csrc = r_csrc + AW'(1);
            n_out_v = 1'b1; n_out_k = lcw_pkg::RK_DATA; n_out_d = w_rdata; n_out_l = 1'b0;
            n_run = r_run - 16'd1;
            if (r_run == 16'd1) n_phase = lcw_pkg::PH_CMD;
        end else if (w_acc) begin
            n_out_v = 1'b1; n_out_k = lcw_pkg::RK_NONE; n_out_d = 8'd0; n_out_l = 1'b0;
            if (i_opcode) begin
                if (r_phase != lcw_pkg::PH_DELIVER) begin
                    n_out_k = lcw_pkg::RK_ERROR;
                end else if (r_kind == lcw_pkg::K_FILL) begin
                    n_emit = 1'b1;
                    n_out_k = lcw_pkg::RK_DATA; n_out_d = r_fill;
                    n_run = r_run - 16'd1;
                    if (r_run == 16'd1) n_phase = lcw_pkg::PH_CMD;
                end else begin
                    n_out_v = 1'b0; n_busy = 1'b1;
                end
            end else if (!i_stream_start && (r_phase == lcw_pkg::PH_DELIVER ||
                                             r_phase == lcw_pkg::PH_DONE)) begin
                n_out_k = lcw_pkg::RK_ERROR;
            end else if (i_stream_start && i_data_in == 8'd0) begin
                n_ocnt = 32'd0; n_widx = '0; n_cons = 24'd0; n_run = 16'd0;
                n_src = 16'd0; n_csrc = '0; n_kind = lcw_pkg::K_LIT;
                n_phase = lcw_pkg::PH_CMD; n_rel = 1'b1;
            end else begin
                if (i_stream_start) begin
                    n_ocnt = 32'd0; n_widx = '0; n_run = 16'd0; n_src = 16'd0;
                    n_csrc = '0; n_kind = lcw_pkg::K_LIT; n_phase = lcw_pkg::PH_CMD;
                    n_rel = 1'b0; cons1 = 24'd1;
                end
                n_cons = cons1;
                if (n_phase == lcw_pkg::PH_CMD) begin
                    if (i_data_in == lcw_pkg::B_END) begin
                        n_out_k = lcw_pkg::RK_END; n_phase = lcw_pkg::PH_DONE;
                    end else if (cons1 >= r_size) begin
                        n_out_k = lcw_pkg::RK_END; n_out_l = 1'b1;
                        n_phase = lcw_pkg::PH_DONE;
                    end else if (i_data_in[7:6] == 2'b10) begin
                        n_kind = lcw_pkg::K_LIT; n_run = {10'd0, i_data_in[5:0]};
                        if (i_data_in[5:0] != 6'd0) n_phase = lcw_pkg::PH_LIT;
                    end else if (!i_data_in[7]) begin
                        n_kind = lcw_pkg::K_SHORT;
                        n_run = 16'({1'b0, i_data_in[6:4]}) + 16'd3;
                        n_src = {4'd0, i_data_in[3:0], 8'd0};
                        n_phase = lcw_pkg::PH_OP0;
                    end else if (i_data_in == lcw_pkg::B_FILL) begin
                        n_kind = lcw_pkg::K_FILL; n_run = 16'd0; n_phase = lcw_pkg::PH_OP0;
                    end else if (i_data_in == lcw_pkg::B_LONG) begin
                        n_kind = lcw_pkg::K_LONG; n_run = 16'd0; n_src = 16'd0;
                        n_phase = lcw_pkg::PH_OP0;
                    end else begin
                        n_kind = lcw_pkg::K_MEDIUM;
                        n_run = 16'(i_data_in[5:0]) + 16'd3;
                        n_src = 16'd0; n_phase = lcw_pkg::PH_OP0;
                    end
                end else if (n_phase == lcw_pkg::PH_LIT) begin
                    n_emit = 1'b1; n_eb = i_data_in;
                    n_out_k = lcw_pkg::RK_DATA; n_out_d = i_data_in;
                    n_run = r_run - 16'd1;
                    if (r_run == 16'd1) n_phase = lcw_pkg::PH_CMD;
                end else begin
                    case (r_kind)
                        lcw_pkg::K_SHORT: begin
                            pos = {r_src[15:8], i_data_in}; rel = 1'b1; start = 1'b1;
                        end
                        lcw_pkg::K_MEDIUM: begin
                            if (r_phase == lcw_pkg::PH_OP0) begin
                                n_src = {8'd0, i_data_in}; n_phase = lcw_pkg::PH_OP1;
                            end else begin
                                pos = {i_data_in, r_src[7:0]}; rel = r_rel; start = 1'b1;
                            end
                        end
                        lcw_pkg::K_FILL: begin
                            if (r_phase == lcw_pkg::PH_OP0) begin
                                n_run = {8'd0, i_data_in}; n_phase = lcw_pkg::PH_OP1;
                            end else if (r_phase == lcw_pkg::PH_OP1) begin
                                n_run = {i_data_in, r_run[7:0]}; n_phase = lcw_pkg::PH_OP2;
                            end else begin
                                n_fill = i_data_in;
                                n_phase = (r_run == 16'd0) ? lcw_pkg::PH_CMD
                                                           : lcw_pkg::PH_DELIVER;
                            end
                        end
                        default: begin
                            if (r_phase == lcw_pkg::PH_OP0) begin
                                n_run = {8'd0, i_data_in}; n_phase = lcw_pkg::PH_OP1;
                            end else if (r_phase == lcw_pkg::PH_OP1) begin
                                n_run = {i_data_in, r_run[7:0]}; n_phase = lcw_pkg::PH_OP2;
                            end else if (r_phase == lcw_pkg::PH_OP2) begin
                                n_src = {8'd0, i_data_in}; n_phase = lcw_pkg::PH_OP3;
                            end else begin
                                pos = {i_data_in, r_src[7:0]}; rel = r_rel; start = 1'b1;
                            end
                        end
                    endcase
                    if (start) begin
                        if (r_run == 16'd0) begin
                            n_phase = lcw_pkg::PH_CMD;
                        end else begin
                            if (rel) begin
                                span = {17'd0, pos};
                                bad = (pos == 16'd0) || ({16'd0, pos} > r_ocnt)
                                      || (span > DEPTH33);
                            end else begin
                                span = {1'b0, r_ocnt} - 33'(pos);
                                bad = ({16'd0, pos} >= r_ocnt) || (span > DEPTH33);
                            end
                            if (bad) begin
                                n_run = 16'd0; n_phase = lcw_pkg::PH_DONE;
                                n_out_k = lcw_pkg::RK_ERROR;
                            end else begin
                                n_csrc = r_widx - span[AW-1:0];
                                n_phase = lcw_pkg::PH_DELIVER;
                            end
                        end
                    end
                end
            end
        end
        if (n_emit) begin
            n_widx = r_widx + AW'(1);
            if (r_ocnt != 32'hffffffff) n_ocnt = r_ocnt + 32'd1;
        end
    end

    assign w_we    = n_emit;
    assign w_wdata = n_eb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 24'd0; r_ocnt <= 32'd0; r_widx <= '0; r_rel <= 1'b0;
            r_phase <= lcw_pkg::PH_CMD; r_kind <= lcw_pkg::K_LIT; r_run <= 16'd0;
            r_src <= 16'd0; r_csrc <= '0; r_fill <= 8'd0; r_cons <= 24'd0;
            r_busy <= 1'b0; r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_wdata;
            r_ocnt <= n_ocnt; r_widx <= n_widx; r_rel <= n_rel; r_phase <= n_phase;
            r_kind <= n_kind; r_run <= n_run; r_src <= n_src; r_csrc <= n_csrc;
            r_fill <= n_fill; r_cons <= n_cons; r_busy <= n_busy; r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy || w_acc) begin
            r_out_k <= n_out_k; r_out_d <= n_out_d; r_out_l <= n_out_l;
            r_out_p <= (n_phase == lcw_pkg::PH_DELIVER);
        end
    end

    assign o_valid          = r_out_v;
    assign o_result_kind    = r_out_k;
    assign o_data_out       = r_out_d;
    assign o_output_pending = r_out_p;
    assign o_limit_reached  = r_out_l;

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy) else $error("copy read held longer than one cycle");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_v) else $error("copy read did not produce a result");
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("transaction accepted during copy read");
    a_limit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_l) |-> (r_out_k == lcw_pkg::RK_END))
        else $error("limit flag without end of stream");
endmodule

// ===== test/lcw_decompressor_core_test.sv =====
// Self-checking testbench for the LCW decompressor core with random stalls and streams.
`timescale 1ns / 100ps

module lcw_decompressor_core_test;

    localparam int unsigned DEPTH = lcw_pkg::HISTORY_DEPTH_DEF;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_in;
        logic       stream_start;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       pending;
        logic       limit;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [23:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [7:0]  i_data_in;
    logic        i_stream_start;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_data_out;
    logic        o_output_pending;
    logic        o_limit_reached;

    lcw_decompressor_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_opcode(i_opcode), .i_data_in(i_data_in),
        .i_stream_start(i_stream_start), .o_valid(o_valid), .i_ready(i_ready),
        .o_result_kind(o_result_kind), .o_data_out(o_data_out),
        .o_output_pending(o_output_pending), .o_limit_reached(o_limit_reached)
    );

    // predictor state
    logic [7:0]  hist [DEPTH];
    logic [31:0] out_count;
    logic [31:0] wr_idx;
    logic        rel_mode;
    logic [2:0]  phase;
    logic [2:0]  cmd;
    logic [15:0] run_cnt;
    logic [31:0] src;
    logic [7:0]  fill_val;
    logic [23:0] consumed;
    logic [23:0] csize;

    t_item       pending_items [$];
    t_result     expected_results [$];
    int          errors;
    int          cycles;
    int          accepted_in;
    int          checked_out;
    bit          idle_off;
    bit          hold_off;
    bit          hold_req;
    int          hold_left;
    int          data_seen;
    int          end_seen;
    // acceptance flag captured at the rising edge for the driver's next decision
    bit          o_ready_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input t_result got,
                                   input t_result want);
        $display("mismatch %s: got kind %0d data %02h pend %0b lim %0b, want %0d %02h %0b %0b",
                 what, got.kind, got.data, got.pending, got.limit,
                 want.kind, want.data, want.pending, want.limit);
        errors++;
    endtask

    function automatic void reset_model();
        out_count = '0; wr_idx = '0; rel_mode = 1'b0; phase = lcw_pkg::PH_CMD;
        cmd = lcw_pkg::K_LIT; run_cnt = '0; src = '0; fill_val = '0; consumed = '0;
        csize = '0;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        hist[wr_idx[AW-1:0]] = b;
        wr_idx = (wr_idx + 32'd1) % DEPTH;
        if (out_count != 32'hffff_ffff) out_count++;
    endfunction

    function automatic void bump_consumed();
        if (consumed < 24'hff_ffff) consumed++;
    endfunction

    function automatic logic [1:0] begin_copy(input logic [31:0] pos, input logic rel);
        logic [31:0] span;
        if (run_cnt == 16'd0) begin
            phase = lcw_pkg::PH_CMD;
            return lcw_pkg::RK_NONE;
        end
        if (cmd == lcw_pkg::K_FILL) begin
            phase = lcw_pkg::PH_DELIVER;
            return lcw_pkg::RK_NONE;
        end
        if (rel) begin
            if (pos == 32'd0 || pos > out_count || pos > DEPTH) begin
                run_cnt = '0; phase = lcw_pkg::PH_DONE; return lcw_pkg::RK_ERROR;
            end
            span = pos;
        end else begin
            if (pos >= out_count || out_count - pos > DEPTH) begin
                run_cnt = '0; phase = lcw_pkg::PH_DONE; return lcw_pkg::RK_ERROR;
            end
            span = out_count - pos;
        end
        src = (wr_idx + DEPTH - span) % DEPTH;
        phase = lcw_pkg::PH_DELIVER;
        return lcw_pkg::RK_NONE;
    endfunction

    function automatic t_result decode_item(input t_item it);
        t_result     r;
        logic [7:0]  b;
        logic [7:0]  v;
        logic [2:0]  idx;
        bit          handled;
        r = '0;
        b = it.data_in;
        handled = 1'b0;
        if (it.opcode) begin
            if (phase != lcw_pkg::PH_DELIVER) r.kind = lcw_pkg::RK_ERROR;
            else begin
                if (cmd == lcw_pkg::K_FILL) v = fill_val;
                else begin
                    v = hist[src[AW-1:0]];
                    src = (src + 32'd1) % DEPTH;
                end
                put_byte(v);
                r.kind = lcw_pkg::RK_DATA; r.data = v;
                run_cnt = run_cnt - 16'd1;
                if (run_cnt == 16'd0) phase = lcw_pkg::PH_CMD;
            end
        end else if (!it.stream_start && (phase == lcw_pkg::PH_DELIVER ||
                                          phase == lcw_pkg::PH_DONE)) begin
            r.kind = lcw_pkg::RK_ERROR;
        end else begin
            if (it.stream_start) begin
                out_count = '0; wr_idx = '0; consumed = '0; run_cnt = '0; src = '0;
                cmd = lcw_pkg::K_LIT; phase = lcw_pkg::PH_CMD;
                rel_mode = (b == 8'd0);
                handled = (b == 8'd0);
            end
            if (!handled && phase == lcw_pkg::PH_CMD) begin
                bump_consumed();
                if (b == lcw_pkg::B_END) begin
                    r.kind = lcw_pkg::RK_END; phase = lcw_pkg::PH_DONE;
                end else if (consumed >= csize) begin
                    r.kind = lcw_pkg::RK_END; r.limit = 1'b1; phase = lcw_pkg::PH_DONE;
                end else if ((b & 8'hc0) == 8'h80) begin
                    cmd = lcw_pkg::K_LIT; run_cnt = {8'd0, b & 8'h3f};
                    if (run_cnt != 16'd0) phase = lcw_pkg::PH_LIT;
                end else if (!b[7]) begin
                    cmd = lcw_pkg::K_SHORT; run_cnt = 16'(((b & 8'h70) >> 4) + 8'd3);
                    src = {20'd0, b[3:0], 8'd0}; phase = lcw_pkg::PH_OP0;
                end else if (b == lcw_pkg::B_FILL) begin
                    cmd = lcw_pkg::K_FILL; run_cnt = '0; phase = lcw_pkg::PH_OP0;
                end else if (b == lcw_pkg::B_LONG) begin
                    cmd = lcw_pkg::K_LONG; run_cnt = '0; src = '0; phase = lcw_pkg::PH_OP0;
                end else begin
                    cmd = lcw_pkg::K_MEDIUM; run_cnt = 16'((b & 8'h3f) + 8'd3); src = '0;
                    phase = lcw_pkg::PH_OP0;
                end
            end else if (!handled && phase == lcw_pkg::PH_LIT) begin
                bump_consumed();
                put_byte(b);
                r.kind = lcw_pkg::RK_DATA; r.data = b;
                run_cnt = run_cnt - 16'd1;
                if (run_cnt == 16'd0) phase = lcw_pkg::PH_CMD;
            end else if (!handled) begin
                idx = phase - lcw_pkg::PH_OP0;
                bump_consumed();
                case (cmd)
                    lcw_pkg::K_SHORT: r.kind = begin_copy(src | {24'd0, b}, 1'b1);
                    lcw_pkg::K_MEDIUM: begin
                        if (idx == 3'd0) begin src = {24'd0, b}; phase++; end
                        else r.kind = begin_copy(src | {16'd0, b, 8'd0}, rel_mode);
                    end
                    lcw_pkg::K_FILL: begin
                        if (idx == 3'd0) begin run_cnt = {8'd0, b}; phase++; end
                        else if (idx == 3'd1) begin run_cnt[15:8] = b; phase++; end
                        else begin fill_val = b; r.kind = begin_copy(32'd0, 1'b0); end
                    end
                    default: begin
                        if (idx == 3'd0) begin run_cnt = {8'd0, b}; phase++; end
                        else if (idx == 3'd1) begin run_cnt[15:8] = b; phase++; end
                        else if (idx == 3'd2) begin src = {24'd0, b}; phase++; end
                        else r.kind = begin_copy(src | {16'd0, b, 8'd0}, rel_mode);
                    end
                endcase
            end
        end
        r.pending = (phase == lcw_pkg::PH_DELIVER);
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_seen) begin
                if (pending_items.size() > 0 && (idle_off || $urandom_range(99) >= 37)) begin
                    t_item it;
                    it = pending_items.pop_front();
                    i_opcode <= it.opcode;
                    i_data_in <= it.data_in;
                    i_stream_start <= it.stream_start;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !hold_off && (idle_off || $urandom_range(99) >= 37);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            cycles++;
            if (i_valid && o_ready) begin
                expected_results.push_back(
                    decode_item(t_item'{i_opcode, i_data_in, i_stream_start}));
                accepted_in++;
            end
            if (o_valid && i_ready) begin
                t_result got, want;
                got = t_result'{o_result_kind, o_data_out, o_output_pending, o_limit_reached};
                checked_out++;
                if (got.kind == lcw_pkg::RK_DATA) data_seen++;
                if (got.kind == lcw_pkg::RK_END) end_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", got, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind) report_mismatch("kind", got, want);
                    if (got.data != want.data) report_mismatch("data", got, want);
                    if (got.pending != want.pending) report_mismatch("pending", got, want);
                    if (got.limit != want.limit) report_mismatch("limit", got, want);
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req && !hold_off) begin
            hold_off <= 1'b1;
            hold_left <= 300;
        end else if (hold_off) begin
            if (hold_left == 0) hold_off <= 1'b0;
            else hold_left <= hold_left - 1;
        end
    end

    function automatic t_item push_b(input logic [7:0] b, input logic st = 1'b0);
        return t_item'{1'b0, b, st};
    endfunction

    function automatic t_item req_b();
        return t_item'{1'b1, 8'($urandom), 1'b0};
    endfunction

    // well-formed stream with random content; sometimes broken
    task automatic queue_stream(input int ncmd);
        int produced;
        int n;
        int p;
        bit rel;
        rel = 1'($urandom_range(1));
        pending_items.push_back(push_b(rel ? 8'h00 : 8'h81, 1'b1));
        produced = 0;
        if (!rel) begin
            pending_items.push_back(push_b(8'($urandom)));
            produced = 1;
        end
        for (int c = 0; c < ncmd; c++) begin
            case ($urandom_range(5))
                0: begin
                    n = $urandom_range(1, 6);
                    pending_items.push_back(push_b(8'h80 | 8'(n)));
                    for (int k = 0; k < n; k++) pending_items.push_back(push_b(8'($urandom)));
                    produced += n;
                end
                1: begin
                    n = $urandom_range(7);
                    p = produced > 0 ? $urandom_range(1, produced > 4095 ? 4095 : produced) : 1;
                    if ($urandom_range(15) == 0) p = $urandom_range(4095);
                    pending_items.push_back(push_b(8'(n << 4) | 8'(p >> 8)));
                    pending_items.push_back(push_b(8'(p)));
                    for (int k = 0; k < n + 3; k++) pending_items.push_back(req_b());
                    produced += n + 3;
                end
                2: begin
                    n = $urandom_range(5);
                    pending_items.push_back(push_b(8'hc0 | 8'(n)));
                    p = produced > 0 ? (rel ? $urandom_range(1, produced)
                                            : $urandom_range(produced - 1)) : 0;
                    if ($urandom_range(15) == 0) p = int'($urandom);
                    pending_items.push_back(push_b(8'(p)));
                    pending_items.push_back(push_b(8'(p >> 8)));
                    for (int k = 0; k < n + 3; k++) pending_items.push_back(req_b());
                    produced += n + 3;
                end
                3: begin
                    n = $urandom_range(6);
                    pending_items.push_back(push_b(lcw_pkg::B_FILL));
                    pending_items.push_back(push_b(8'(n)));
                    pending_items.push_back(push_b(8'h00));
                    pending_items.push_back(push_b(8'($urandom)));
                    for (int k = 0; k < n; k++) pending_items.push_back(req_b());
                    produced += n;
                end
                4: begin
                    n = $urandom_range(6);
                    pending_items.push_back(push_b(lcw_pkg::B_LONG));
                    pending_items.push_back(push_b(8'(n)));
                    pending_items.push_back(push_b(8'h00));
                    p = produced > 0 ? (rel ? $urandom_range(1, produced)
                                            : $urandom_range(produced - 1)) : 0;
                    pending_items.push_back(push_b(8'(p)));
                    pending_items.push_back(push_b(8'(p >> 8)));
                    if (n > 0 && produced == 0) n = 0;
                    for (int k = 0; k < n; k++) pending_items.push_back(req_b());
                    produced += n;
                end
                default: begin
                    // noise: random request or push
                    pending_items.push_back(
                        t_item'{1'($urandom_range(1)), 8'($urandom), 1'b0});
                end
            endcase
        end
        if ($urandom_range(3) != 0) pending_items.push_back(push_b(lcw_pkg::B_END));
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [23:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        csize = v;
    endtask

    initial begin
        errors = 0; cycles = 0; accepted_in = 0; checked_out = 0;
        data_seen = 0; end_seen = 0;
        idle_off = 0; hold_off = 0; hold_req = 0; hold_left = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0; i_valid = 1'b0;
        i_opcode = 1'b0; i_data_in = '0; i_stream_start = 1'b0; i_ready = 1'b0;
        reset_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // size zero: first command stops at the limit
        pending_items.push_back(push_b(8'h81, 1'b1));
        pending_items.push_back(push_b(8'h55));
        wait_drained();

        write_size(24'hff_ffff);
        // directed: literals, bad refs and misuse; the fill and end bytes arrive after an error
        pending_items.push_back(push_b(8'h00, 1'b1));
        pending_items.push_back(t_item'{1'b1, 8'h00, 1'b0});
        pending_items.push_back(push_b(8'h82));
        pending_items.push_back(push_b(8'hff));
        pending_items.push_back(push_b(8'h00));
        pending_items.push_back(push_b(8'h01));
        pending_items.push_back(push_b(8'h01));
        pending_items.push_back(push_b(8'hab));
        pending_items.push_back(t_item'{1'b1, 8'hff, 1'b0});
        pending_items.push_back(push_b(lcw_pkg::B_FILL));
        pending_items.push_back(push_b(8'h02));
        pending_items.push_back(push_b(8'h00));
        pending_items.push_back(push_b(8'h3c));
        pending_items.push_back(t_item'{1'b1, 8'h00, 1'b0});
        pending_items.push_back(t_item'{1'b1, 8'h00, 1'b0});
        pending_items.push_back(push_b(8'h80));
        pending_items.push_back(push_b(8'h12));
        pending_items.push_back(push_b(8'hc0, 1'b1));
        pending_items.push_back(push_b(8'h0f));
        pending_items.push_back(push_b(8'hff));
        wait_drained();

        write_size(24'd6);
        for (int s = 0; s < 10; s++) queue_stream(4);
        wait_drained();

        write_size(24'hff_ffff);
        idle_off = 1;
        for (int s = 0; s < 10; s++) queue_stream(6);
        wait_drained();
        idle_off = 0;

        hold_req = 1;
        for (int s = 0; s < 5; s++) queue_stream(6);
        @(posedge i_clk);
        @(negedge i_clk);
        hold_req = 0;
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            write_size(ph == 0 ? 24'd1 : 24'(($urandom_range(10, 200))));
            while (pending_items.size() < 250) queue_stream($urandom_range(2, 12));
            wait_drained();
        end

        $display("accepted %0d items, checked %0d results (%0d data, %0d end of stream)",
                 accepted_in, checked_out, data_seen, end_seen);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
